// ===== rtl/rbh_pkg.sv =====
// Shared constants, arc tangent table and pipeline side-band types for the
// radar beam height and ground range core. No dependencies.
`timescale 1ns / 1ps

package rbh_pkg;

   // CORDIC depth, one stage per iteration
   localparam int CORDIC_STAGES = 24;
   // Square root stages, one result bit each (64-bit radicand)
   localparam int ISQ_STAGES = 32;
   // Accept, angle, rotation, clamp, multiply, add, radicand, root, height,
   // vectoring, ground multiply, output register
   localparam int RBH_LAT = 2 * CORDIC_STAGES + ISQ_STAGES + 9;

   localparam logic signed [32:0] GAIN_Q30       = 33'sd652032874;
   localparam logic [33:0]        CDEG_TO_RAD_Q46 = 34'd12281662764;
   localparam logic [23:0]        RADIUS_RESET    = 24'd8494667;
   localparam logic signed [14:0] ELEV_MAX        = 15'sd9000;
   localparam logic signed [14:0] ELEV_MIN        = -15'sd9000;

   // Side band carried through the square root pipeline
   typedef struct packed {
      logic [32:0] xg;
      logic [28:0] yg;
      logic [23:0] radius;
   } isq_side_type;

   // Side band carried through the vectoring pipeline
   typedef struct packed {
      logic signed [20:0] height;
      logic [23:0]        radius;
   } vec_side_type;

   // atan(2^-i) in Q30 radians
   function automatic logic signed [32:0] atan_q30(input int i);
      logic signed [32:0] v;
      case (i)
         0:       v = 33'sd843314856;
         1:       v = 33'sd497837829;
         2:       v = 33'sd263043836;
         3:       v = 33'sd133525158;
         4:       v = 33'sd67021686;
         5:       v = 33'sd33543515;
         6:       v = 33'sd16775850;
         7:       v = 33'sd8388437;
         8:       v = 33'sd4194282;
         9:       v = 33'sd2097149;
         10:      v = 33'sd1048575;
         default: v = (i <= 30) ? (33'sd1 <<< (30 - i)) : 33'sd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/rbh_isqrt.sv =====
// Pipelined floor integer square root of a 64-bit radicand, one result bit
// per stage, with a side band carried alongside. Depends on rbh_pkg.
`timescale 1ns / 1ps

module rbh_isqrt
   import rbh_pkg::*;
(
   input  logic         clock,
   input  logic         en,
   input  logic [63:0]  radicand,
   input  isq_side_type side_in,
   output logic [31:0]  root,
   output isq_side_type side_out
);

   logic [63:0]  rem_ff  [0:ISQ_STAGES-1];
   logic [63:0]  res_ff  [0:ISQ_STAGES-1];
   isq_side_type side_ff [0:ISQ_STAGES-1];

   genvar k;
   generate
      for (k = 0; k < ISQ_STAGES; k++) begin : g_stage
         localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
         logic [63:0]  rem_prev, res_prev, rem_in, res_in;
         logic [64:0]  trial;
         isq_side_type side_prev;

         if (k == 0) begin : g_first
            assign rem_prev  = radicand;
            assign res_prev  = 64'd0;
            assign side_prev = side_in;
         end else begin : g_next
            assign rem_prev  = rem_ff[k-1];
            assign res_prev  = res_ff[k-1];
            assign side_prev = side_ff[k-1];
         end

         // restoring step: try to subtract res + bit
         always_comb begin
            trial = {1'b0, res_prev} + {1'b0, BIT};
            if ({1'b0, rem_prev} >= trial) begin
               rem_in = rem_prev - trial[63:0];
               res_in = (res_prev >> 1) + BIT;
            end else begin
               rem_in = rem_prev;
               res_in = res_prev >> 1;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k]  <= rem_in;
               res_ff[k]  <= res_in;
               side_ff[k] <= side_prev;
            end
         end
      end
   endgenerate

   assign root     = res_ff[ISQ_STAGES-1][31:0];
   assign side_out = side_ff[ISQ_STAGES-1];

endmodule

// ===== rtl/rbh_cordic_vec.sv =====
// Pipelined vectoring CORDIC: angle of (x, y) in Q30, zero when y starts at
// zero, with a side band carried alongside. Depends on rbh_pkg.
`timescale 1ns / 1ps

module rbh_cordic_vec
   import rbh_pkg::*;
(
   input  logic               clock,
   input  logic               en,
   input  logic [32:0]        x_in,
   input  logic [28:0]        y_in,
   input  vec_side_type       side_in,
   output logic signed [32:0] angle,
   output vec_side_type       side_out
);

   logic signed [35:0] vx_ff    [0:CORDIC_STAGES-1];
   logic signed [35:0] vy_ff    [0:CORDIC_STAGES-1];
   logic signed [32:0] vz_ff    [0:CORDIC_STAGES-1];
   logic               yzero_ff [0:CORDIC_STAGES-1];
   vec_side_type       side_ff  [0:CORDIC_STAGES-1];

   genvar k;
   generate
      for (k = 0; k < CORDIC_STAGES; k++) begin : g_stage
         logic signed [35:0] xp, yp, x_in_k, y_in_k;
         logic signed [32:0] zp, z_in_k;
         logic               zp_flag;
         vec_side_type       sp;

         if (k == 0) begin : g_first
            assign xp      = $signed({3'b000, x_in});
            assign yp      = $signed({7'd0, y_in});
            assign zp      = 33'sd0;
            assign zp_flag = (y_in == 29'd0);
            assign sp      = side_in;
         end else begin : g_next
            assign xp      = vx_ff[k-1];
            assign yp      = vy_ff[k-1];
            assign zp      = vz_ff[k-1];
            assign zp_flag = yzero_ff[k-1];
            assign sp      = side_ff[k-1];
         end

         // drive y toward zero
         always_comb begin
            if (yp > 36'sd0) begin
               x_in_k = xp + (yp >>> k);
               y_in_k = yp - (xp >>> k);
               z_in_k = zp + atan_q30(k);
            end else begin
               x_in_k = xp - (yp >>> k);
               y_in_k = yp + (xp >>> k);
               z_in_k = zp - atan_q30(k);
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               vx_ff[k]    <= x_in_k;
               vy_ff[k]    <= y_in_k;
               vz_ff[k]    <= z_in_k;
               yzero_ff[k] <= zp_flag;
               side_ff[k]  <= sp;
            end
         end
      end
   endgenerate

   assign angle    = yzero_ff[CORDIC_STAGES-1] ? 33'sd0 : vz_ff[CORDIC_STAGES-1];
   assign side_out = side_ff[CORDIC_STAGES-1];

endmodule

// ===== rtl/radar_beam_height_and_ground_range_core.sv =====
// Top level: beam height and ground range under the effective earth radius
// model. Depends on rbh_pkg, rbh_isqrt and rbh_cordic_vec.
`timescale 1ns / 1ps

// Usage
//   Input channel req_*: elevation in hundredths of a degree and slant range
//   in meters; a transaction completes when req_valid is high and req_stall
//   is low. Result channel rsp_*: beam height and ground range in meters.
//   csr_*: writes the effective earth radius; csr_ready is always high and
//   the register should be written only while no transaction is in flight.
// Throughput and pipeline
//   One transaction per cycle while the result channel is not stalled. The
//   pipeline holds the rotation CORDIC, the 32-stage square root and the
//   vectoring CORDIC in series.
// Reset
//   Synchronous, active high: empties the pipeline and loads the radius
//   with four thirds of the mean earth radius.
// Stall
//   The whole pipeline freezes while rsp_valid is high and rsp_stall is
//   high; req_stall follows, so nothing in flight is lost or repeated.
module radar_beam_height_and_ground_range_core
   import rbh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [14:0] req_elevation_cdeg,
   input  logic [19:0]        req_slant_range_m,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [20:0] rsp_height_m,
   output logic [19:0]        rsp_ground_range_m,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [23:0]        csr_effective_radius_m
);

   localparam int N = CORDIC_STAGES;

   logic        en;
   logic [RBH_LAT-1:0] vld_ff;
   logic [23:0] radius_ff;

   // global advance: hold everything while the result is stalled
   assign en        = !(vld_ff[RBH_LAT-1] && rsp_stall);
   assign req_stall = !en;
   assign rsp_valid = vld_ff[RBH_LAT-1];
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
      end else if (csr_valid) begin
         radius_ff <= csr_effective_radius_m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[RBH_LAT-2:0], req_valid};
      end
   end

   // stage 0: clamp elevation, split sign and magnitude
   logic signed [14:0] e_clamp;
   logic [14:0] e_mag;
   logic        neg0_ff;
   logic [13:0] mag0_ff;
   logic [19:0] r0_ff;
   logic [23:0] a0_ff;

   always_comb begin
      if (req_elevation_cdeg > ELEV_MAX) begin
         e_clamp = ELEV_MAX;
      end else if (req_elevation_cdeg < ELEV_MIN) begin
         e_clamp = ELEV_MIN;
      end else begin
         e_clamp = req_elevation_cdeg;
      end
      e_mag = e_clamp[14] ? 15'(-e_clamp) : 15'(e_clamp);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg0_ff <= req_elevation_cdeg[14];
         mag0_ff <= e_mag[13:0];
         r0_ff   <= req_slant_range_m;
         a0_ff   <= radius_ff;
      end
   end

   // stage 1: hundredths of a degree to Q30 radians
   logic [47:0]        theta_prod;
   logic signed [32:0] theta1_ff;
   logic               neg1_ff;
   logic [19:0]        r1_ff;
   logic [23:0]        a1_ff;

   assign theta_prod = 48'(mag0_ff) * 48'(CDEG_TO_RAD_Q46);

   always_ff @(posedge clock) begin
      if (en) begin
         theta1_ff <= $signed(33'((theta_prod + 48'd32768) >> 16));
         neg1_ff   <= neg0_ff;
         r1_ff     <= r0_ff;
         a1_ff     <= a0_ff;
      end
   end

   // rotation CORDIC for cos and sin of the magnitude
   logic signed [32:0] rx_ff   [0:N-1];
   logic signed [32:0] ry_ff   [0:N-1];
   logic signed [32:0] rz_ff   [0:N-1];
   logic               rneg_ff [0:N-1];
   logic [19:0]        rr_ff   [0:N-1];
   logic [23:0]        ra_ff   [0:N-1];

   genvar k;
   generate
      for (k = 0; k < N; k++) begin : g_rot
         logic signed [32:0] xp, yp, zp, x_in_k, y_in_k, z_in_k;
         logic               np;
         logic [19:0]        rp;
         logic [23:0]        ap;

         if (k == 0) begin : g_first
            assign xp = GAIN_Q30;
            assign yp = 33'sd0;
            assign zp = theta1_ff;
            assign np = neg1_ff;
            assign rp = r1_ff;
            assign ap = a1_ff;
         end else begin : g_next
            assign xp = rx_ff[k-1];
            assign yp = ry_ff[k-1];
            assign zp = rz_ff[k-1];
            assign np = rneg_ff[k-1];
            assign rp = rr_ff[k-1];
            assign ap = ra_ff[k-1];
         end

         always_comb begin
            if (zp >= 33'sd0) begin
               x_in_k = xp - (yp >>> k);
               y_in_k = yp + (xp >>> k);
               z_in_k = zp - atan_q30(k);
            end else begin
               x_in_k = xp + (yp >>> k);
               y_in_k = yp - (xp >>> k);
               z_in_k = zp + atan_q30(k);
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rx_ff[k]   <= x_in_k;
               ry_ff[k]   <= y_in_k;
               rz_ff[k]   <= z_in_k;
               rneg_ff[k] <= np;
               rr_ff[k]   <= rp;
               ra_ff[k]   <= ap;
            end
         end
      end
   endgenerate

   // clamp stage: cos, sin into [0, 1.0]; first products
   localparam logic signed [32:0] ONE_Q30 = 33'sd1073741824;
   logic [30:0] c_in, s_in;
   logic [30:0] c_ff, s_ff;
   logic [43:0] p_ff;
   logic [39:0] r2_ff;
   logic [47:0] a2_ff;
   logic        negc_ff;
   logic [19:0] rc_r_ff;
   logic [23:0] ac_ff;

   always_comb begin
      if (rx_ff[N-1] < 33'sd0) begin
         c_in = 31'd0;
      end else if (rx_ff[N-1] > ONE_Q30) begin
         c_in = 31'(ONE_Q30);
      end else begin
         c_in = rx_ff[N-1][30:0];
      end
      if (ry_ff[N-1] < 33'sd0) begin
         s_in = 31'd0;
      end else if (ry_ff[N-1] > ONE_Q30) begin
         s_in = 31'(ONE_Q30);
      end else begin
         s_in = ry_ff[N-1][30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff    <= c_in;
         s_ff    <= s_in;
         p_ff    <= 44'(ra_ff[N-1]) * 44'(rr_ff[N-1]);
         r2_ff   <= 40'(rr_ff[N-1]) * 40'(rr_ff[N-1]);
         a2_ff   <= 48'(ra_ff[N-1]) * 48'(ra_ff[N-1]);
         negc_ff <= rneg_ff[N-1];
         rc_r_ff <= rr_ff[N-1];
         ac_ff   <= ra_ff[N-1];
      end
   end

   // multiply stage: cross term halves, base, range times cos and sin
   logic [59:0] thi_ff;
   logic [58:0] tlo_ff;
   logic [62:0] base_ff;
   logic [50:0] rs_ff, rcos_ff;
   logic        negm_ff;
   logic [23:0] am_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         thi_ff  <= 60'(p_ff) * 60'(s_ff[30:15]);
         tlo_ff  <= 59'(p_ff) * 59'(s_ff[14:0]);
         base_ff <= 63'(49'(r2_ff) + 49'(a2_ff)) << 14;
         rs_ff   <= 51'(rc_r_ff) * 51'(s_ff);
         rcos_ff <= 51'(rc_r_ff) * 51'(c_ff);
         negm_ff <= negc_ff;
         am_ff   <= ac_ff;
      end
   end

   // add stage: full cross term and vectoring start point
   logic signed [34:0] xs;
   logic [60:0] t_ff;
   logic [62:0] basea_ff;
   logic [32:0] xg_ff;
   logic [28:0] yg_ff;
   logic        nega_ff;
   logic [23:0] aa_ff;

   always_comb begin
      if (negm_ff) begin
         xs = $signed({3'b000, am_ff, 8'd0}) - $signed({6'd0, rs_ff[50:22]});
      end else begin
         xs = $signed({3'b000, am_ff, 8'd0}) + $signed({6'd0, rs_ff[50:22]});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff     <= 61'(thi_ff) + 61'(tlo_ff >> 15);
         basea_ff <= base_ff;
         xg_ff    <= xs[34] ? 33'(-xs) : xs[32:0];
         yg_ff    <= rcos_ff[50:22];
         nega_ff  <= negm_ff;
         aa_ff    <= am_ff;
      end
   end

   // radicand stage: floor at zero for downward beams
   logic [63:0]  d_in, d_ff;
   isq_side_type sd_ff;

   always_comb begin
      if (nega_ff) begin
         d_in = (64'(basea_ff) >= 64'(t_ff)) ? 64'(basea_ff) - 64'(t_ff) : 64'd0;
      end else begin
         d_in = 64'(basea_ff) + 64'(t_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff         <= d_in;
         sd_ff.xg     <= xg_ff;
         sd_ff.yg     <= yg_ff;
         sd_ff.radius <= aa_ff;
      end
   end

   logic [31:0]  root;
   isq_side_type sq_side;

   rbh_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .radicand (d_ff),
      .side_in  (sd_ff),
      .root     (root),
      .side_out (sq_side)
   );

   // height stage: subtract radius, round, saturate
   logic signed [33:0] h7;
   logic signed [26:0] hr;
   logic signed [20:0] h_sat;
   logic [32:0]  xh_ff;
   logic [28:0]  yh_ff;
   vec_side_type vh_ff;

   always_comb begin
      h7 = $signed({2'b00, root}) - $signed({3'b000, sq_side.radius, 7'd0});
      hr = 27'((h7 + 34'sd64) >>> 7);
      if (hr > 27'sd1048575) begin
         h_sat = 21'sd1048575;
      end else if (hr < -27'sd1048576) begin
         h_sat = -21'sd1048576;
      end else begin
         h_sat = hr[20:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xh_ff        <= sq_side.xg;
         yh_ff        <= sq_side.yg;
         vh_ff.height <= h_sat;
         vh_ff.radius <= sq_side.radius;
      end
   end

   logic signed [32:0] angle;
   vec_side_type       vec_side;

   rbh_cordic_vec u_vec (
      .clock    (clock),
      .en       (en),
      .x_in     (xh_ff),
      .y_in     (yh_ff),
      .side_in  (vh_ff),
      .angle    (angle),
      .side_out (vec_side)
   );

   // ground multiply stage: arc length = radius * angle
   logic [30:0]        z_pos;
   logic [54:0]        gp_ff;
   logic signed [20:0] hg_ff;

   assign z_pos = angle[32] ? 31'd0 : angle[30:0];

   always_ff @(posedge clock) begin
      if (en) begin
         gp_ff <= 55'(vec_side.radius) * 55'(z_pos);
         hg_ff <= vec_side.height;
      end
   end

   // output register: round and saturate ground range
   logic [24:0] g_round;

   assign g_round = 25'((gp_ff + 55'd536870912) >> 30);

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_height_m       <= hg_ff;
         rsp_ground_range_m <= (g_round > 25'd1048575) ? 20'd1048575 : g_round[19:0];
      end
   end

endmodule
